@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWDWR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWDWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/swdwr_pkg.sv @@
`default_nettype none
package swdwr_pkg;

  localparam int DATA_BITS = 32;
  localparam int HDR_W     = 4;
  localparam int ACK_W     = 3;
  localparam int HP_W      = 8;
  localparam int TURN_W    = 3;
  localparam int BIT_CNT_W = 6;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // item operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TURNAROUND  = 1'b1;

  // transfer phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REQUEST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TURN_A  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ACK     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TURN_B  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA    = 3'd5;

  localparam logic [BIT_CNT_W-1:0] REQ_BITS = 6'd8;
  localparam logic [BIT_CNT_W-1:0] ACK_BITS = 6'd3;
  localparam logic [BIT_CNT_W-1:0] DATA_LEN = BIT_CNT_W'(DATA_BITS + 1);

  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  // number of swclk cycles in a phase
  function automatic bit_cnt_t phase_len(input phase_t ph, input logic [TURN_W-1:0] turn);
    bit_cnt_t t;
    bit_cnt_t len;
    t = (turn == '0) ? bit_cnt_t'(1) : bit_cnt_t'(turn);
    unique case (ph)
      PH_REQUEST:         len = REQ_BITS;
      PH_TURN_A, PH_TURN_B: len = t;
      PH_ACK:             len = ACK_BITS;
      PH_DATA:            len = DATA_LEN;
      default:            len = '0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

@@ rtl/swdwr_in_if.sv @@
`default_nettype none
interface swdwr_in_if import swdwr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [HDR_W-1:0]     request_bits;
  logic [DATA_BITS-1:0] write_data;
  logic                 swdio_in;

  modport source (output valid, operation, request_bits, write_data, swdio_in,
                  input ready);
  modport sink (input valid, operation, request_bits, write_data, swdio_in,
                output ready);
endinterface
`default_nettype wire

@@ rtl/swdwr_out_if.sv @@
`default_nettype none
interface swdwr_out_if import swdwr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             swclk_level;
  logic             swdio_level;
  logic             swdio_drive;
  logic [ACK_W-1:0] ack_code;
  logic             busy_res;
  logic             done_res;

  modport source (output valid, swclk_level, swdio_level, swdio_drive, ack_code,
                  busy_res, done_res, input ready);
  modport sink (input valid, swclk_level, swdio_level, swdio_drive, ack_code,
                busy_res, done_res, output ready);
endinterface
`default_nettype wire

@@ rtl/swdwr_cfg_if.sv @@
`default_nettype none
interface swdwr_cfg_if import swdwr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/swd_write_transfer_engine.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid/ready    operation, request_bits, write_data, swdio_in
// out_ch    out  valid/ready    swclk_level, swdio_level, swdio_drive, ack_code,
//                               busy_res, done_res
// cfg_ch    in   valid/ready    reg_index, wdata
//
// one item per clock: each accepted item updates the pin sequencer state and
// loads the result register in the same cycle; its result is offered on the
// next cycle. the result register sets the pace: in_ch.ready is high while
// the result register is empty or being taken. cfg_ch.ready is always high.
// synchronous active-low reset returns to idle with swclk and swdio high.
`default_nettype none
module swd_write_transfer_engine import swdwr_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  swdwr_in_if.sink    in_ch,
  swdwr_out_if.source out_ch,
  swdwr_cfg_if.sink   cfg_ch
);

`include "assert_macros.svh"

  // configuration registers
  logic [HP_W-1:0]   half_period_r;
  logic [TURN_W-1:0] turnaround_r;

  // sequencer state
  phase_t               phase_r, phase_nxt;
  bit_cnt_t             bit_cnt_r, bit_cnt_nxt;
  logic [HP_W-1:0]      half_cnt_r, half_cnt_nxt;
  logic                 clk_high_r, clk_high_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [HDR_W-1:0]     hdr_r, hdr_nxt;
  logic                 par_r, par_nxt;
  logic [ACK_W-1:0]     ack_r, ack_nxt;
  logic                 line_out_r, line_out_nxt;
  logic                 line_drv_r, line_drv_nxt;
  logic                 done_nxt;

  // result register
  logic             out_valid_r;
  logic             out_done_r;

  logic            in_accept;
  logic [HP_W-1:0] hp_eff;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign hp_eff       = (half_period_r == '0) ? HP_W'(1) : half_period_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HP_W'(1);
      turnaround_r  <= TURN_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_HALF_PERIOD: half_period_r <= cfg_ch.wdata;
        REG_TURNAROUND:  turnaround_r  <= cfg_ch.wdata[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // next state of the pin sequencer for the item at the input
  always_comb begin
    logic present;
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    half_cnt_nxt = half_cnt_r;
    clk_high_nxt = clk_high_r;
    shift_nxt    = shift_r;
    hdr_nxt      = hdr_r;
    par_nxt      = par_r;
    ack_nxt      = ack_r;
    line_out_nxt = line_out_r;
    line_drv_nxt = line_drv_r;
    done_nxt     = 1'b0;
    present      = 1'b0;

    if (in_ch.operation == OP_START) begin
      // start is ignored unless idle
      if (phase_r == PH_IDLE) begin
        hdr_nxt      = in_ch.request_bits;
        shift_nxt    = in_ch.write_data;
        par_nxt      = 1'b0;
        ack_nxt      = '0;
        phase_nxt    = PH_REQUEST;
        bit_cnt_nxt  = '0;
        half_cnt_nxt = '0;
        clk_high_nxt = 1'b0;
        present      = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      half_cnt_nxt = half_cnt_r + HP_W'(1);
      if (half_cnt_nxt >= hp_eff) begin
        half_cnt_nxt = '0;
        if (!clk_high_r) begin
          // low half ends: sample ack, raise swclk
          if (phase_r == PH_ACK && bit_cnt_r < ACK_BITS) begin
            ack_nxt[bit_cnt_r[1:0]] = in_ch.swdio_in;
          end
          clk_high_nxt = 1'b1;
        end else begin
          // high half ends: step to the next bit
          bit_cnt_nxt = bit_cnt_r + bit_cnt_t'(1);
          if (bit_cnt_nxt >= phase_len(phase_r, turnaround_r)) begin
            bit_cnt_nxt = '0;
            phase_nxt   = phase_r + phase_t'(1);
          end
          if (phase_nxt > PH_DATA) begin
            phase_nxt    = PH_IDLE;
            line_out_nxt = 1'b1;
            line_drv_nxt = 1'b1;
            done_nxt     = 1'b1;
          end else begin
            present      = 1'b1;
            clk_high_nxt = 1'b0;
          end
        end
      end
    end

    // put the selected bit on swdio
    if (present) begin
      if (phase_nxt == PH_REQUEST) begin
        line_drv_nxt = 1'b1;
        case (bit_cnt_nxt)
          6'd0:    line_out_nxt = 1'b1;
          6'd1:    line_out_nxt = hdr_nxt[0];
          6'd2:    line_out_nxt = hdr_nxt[1];
          6'd3:    line_out_nxt = hdr_nxt[2];
          6'd4:    line_out_nxt = hdr_nxt[3];
          6'd5:    line_out_nxt = ^hdr_nxt;
          6'd6:    line_out_nxt = 1'b0;
          default: line_out_nxt = 1'b1;
        endcase
      end else if (phase_nxt == PH_DATA) begin
        line_drv_nxt = 1'b1;
        if (bit_cnt_nxt < bit_cnt_t'(DATA_BITS)) begin
          line_out_nxt = shift_nxt[0];
          par_nxt      = par_nxt ^ shift_nxt[0];
          shift_nxt    = {1'b0, shift_nxt[DATA_BITS-1:1]};
        end else begin
          line_out_nxt = par_nxt;
        end
      end else begin
        line_drv_nxt = 1'b0;
      end
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      half_cnt_r <= '0;
      clk_high_r <= 1'b1;
      shift_r    <= '0;
      hdr_r      <= '0;
      par_r      <= 1'b0;
      ack_r      <= '0;
      line_out_r <= 1'b1;
      line_drv_r <= 1'b1;
    end else if (in_accept) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      half_cnt_r <= half_cnt_nxt;
      clk_high_r <= clk_high_nxt;
      shift_r    <= shift_nxt;
      hdr_r      <= hdr_nxt;
      par_r      <= par_nxt;
      ack_r      <= ack_nxt;
      line_out_r <= line_out_nxt;
      line_drv_r <= line_drv_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // done flag of the result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_done_r <= done_nxt;
    end
  end

  // pin levels after each item come straight from the state registers
  assign out_ch.valid       = out_valid_r;
  assign out_ch.swclk_level = clk_high_r;
  assign out_ch.swdio_level = line_out_r;
  assign out_ch.swdio_drive = line_drv_r;
  assign out_ch.ack_code    = ack_r;
  assign out_ch.busy_res    = (phase_r != PH_IDLE);
  assign out_ch.done_res    = out_done_r;

  `SWDWR_ASSERT(a_idle_lines_high, phase_r == PH_IDLE, clk_high_r && line_drv_r && line_out_r,
    "idle with swclk or swdio not parked high")
  `SWDWR_ASSERT(a_done_not_busy, out_valid_r && out_done_r, phase_r == PH_IDLE,
    "done reported while still busy")
  `SWDWR_ASSERT(a_req_count, phase_r == PH_REQUEST, bit_cnt_r < REQ_BITS,
    "request bit counter out of range")
  `SWDWR_ASSERT_NEXT(a_accept_result, in_accept, out_valid_r,
    "accepted item gave no result")
  `SWDWR_ASSERT(a_turn_released, phase_r == PH_TURN_A || phase_r == PH_TURN_B, !line_drv_r,
    "swdio driven during turnaround")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top import swdwr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES  = 10;

  // expected pin state after one item
  typedef struct packed {
    logic             swclk;
    logic             swdio;
    logic             drive;
    logic [ACK_W-1:0] ack;
    logic             busy;
    logic             done;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n;

  swdwr_in_if  in_ch ();
  swdwr_out_if out_ch ();
  swdwr_cfg_if cfg_ch ();

  swd_write_transfer_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // sequencer state mirrored from the spec
  logic [HP_W-1:0]      cfg_half;
  logic [TURN_W-1:0]    cfg_turn;
  phase_t               m_phase;
  bit_cnt_t             m_bit;
  logic [HP_W-1:0]      m_hp_cnt;
  logic                 m_clk_high;
  logic [DATA_BITS-1:0] m_shift;
  logic [HDR_W-1:0]     m_hdr;
  logic                 m_par;
  logic [ACK_W-1:0]     m_ack;
  logic                 m_line;
  logic                 m_drive;

  pin_state_t pin_q[$];
  int         errors     = 0;
  int         items_sent = 0;
  int         cycles     = 0;
  bit         gaps_on    = 1'b1;
  int         hold_req   = 0;
  int         hold_seen  = 0;
  int         stall_left = 0;

  // swclk cycles spent in each phase
  function automatic int cycles_in_phase(phase_t ph);
    int turn;
    turn = (cfg_turn == '0) ? 1 : int'(cfg_turn);
    case (ph)
      PH_REQUEST:           return 8;
      PH_TURN_A, PH_TURN_B: return turn;
      PH_ACK:               return ACK_W;
      PH_DATA:              return DATA_BITS + 1;
      default:              return 0;
    endcase
  endfunction

  // put the bit for the current phase and position on swdio
  function automatic void drive_next_bit();
    if (m_phase == PH_REQUEST) begin
      m_drive = 1'b1;
      if (m_bit == 0) m_line = 1'b1;
      else if (m_bit <= 4) m_line = m_hdr[2'(m_bit - bit_cnt_t'(1))];
      else if (m_bit == 5) m_line = ^m_hdr;
      else if (m_bit == 6) m_line = 1'b0;
      else m_line = 1'b1;
    end else if (m_phase == PH_DATA) begin
      m_drive = 1'b1;
      if (m_bit < DATA_BITS) begin
        m_line  = m_shift[0];
        m_par   = m_par ^ m_line;
        m_shift = m_shift >> 1;
      end else begin
        m_line = m_par;
      end
    end else begin
      m_drive = 1'b0;
    end
  endfunction

  // advance the pin sequencer by one item and return the expected pins
  function automatic pin_state_t step_pins(logic op, logic [HDR_W-1:0] req,
                                           logic [DATA_BITS-1:0] wd, logic sdio);
    pin_state_t       res;
    logic [HP_W-1:0]  hp;
    logic             fin;
    fin = 1'b0;
    hp  = (cfg_half == '0) ? HP_W'(1) : cfg_half;
    if (op == OP_START) begin
      // a start while busy is dropped
      if (m_phase == PH_IDLE) begin
        m_hdr      = req;
        m_shift    = wd;
        m_par      = 1'b0;
        m_ack      = '0;
        m_phase    = PH_REQUEST;
        m_bit      = '0;
        m_hp_cnt   = '0;
        m_clk_high = 1'b0;
        drive_next_bit();
      end
    end else if (m_phase != PH_IDLE) begin
      m_hp_cnt = m_hp_cnt + HP_W'(1);
      if (m_hp_cnt >= hp) begin
        m_hp_cnt = '0;
        if (!m_clk_high) begin
          // end of low half: sample ack, raise swclk
          if (m_phase == PH_ACK && m_bit < ACK_W)
            m_ack = m_ack | (ACK_W'(sdio) << m_bit);
          m_clk_high = 1'b1;
        end else begin
          m_bit = m_bit + bit_cnt_t'(1);
          if (int'(m_bit) >= cycles_in_phase(m_phase)) begin
            m_bit   = '0;
            m_phase = m_phase + phase_t'(1);
          end
          if (m_phase > PH_DATA) begin
            m_phase = PH_IDLE;
            m_line  = 1'b1;
            m_drive = 1'b1;
            fin     = 1'b1;
          end else begin
            drive_next_bit();
            m_clk_high = 1'b0;
          end
        end
      end
    end
    res.swclk = m_clk_high;
    res.swdio = m_line;
    res.drive = m_drive;
    res.ack   = m_ack;
    res.busy  = (m_phase != PH_IDLE);
    res.done  = fin;
    return res;
  endfunction

  // offer one item, with an occasional idle burst first
  task automatic send_item(input logic op, input logic [HDR_W-1:0] req,
                           input logic [DATA_BITS-1:0] wd, input logic sdio);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.request_bits <= req;
    in_ch.write_data   <= wd;
    in_ch.swdio_in     <= sdio;
    do @(posedge clk); while (!in_ch.ready);
    pin_q.push_back(step_pins(op, req, wd, sdio));
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pin_q.size() != 0);
  endtask

  // write both timing registers while the engine is idle
  task automatic set_timing(input logic [CFG_DAT_W-1:0] hp_val,
                            input logic [CFG_DAT_W-1:0] ta_val);
    wait_idle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_HALF_PERIOD;
    cfg_ch.wdata     <= hp_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_half = hp_val;
    cfg_ch.reg_index <= REG_TURNAROUND;
    cfg_ch.wdata     <= ta_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_turn = ta_val[TURN_W-1:0];
    cfg_ch.valid <= 1'b0;
  endtask

  // one full write transfer; a start lands mid-transfer at least once
  task automatic run_transfer(input logic [HDR_W-1:0] req, input logic [DATA_BITS-1:0] wd,
                              input bit rand_line, input logic line_val, input int noise_pct);
    int n;
    n = 0;
    send_item(OP_START, req, wd, rand_line ? logic'($urandom_range(0, 1)) : line_val);
    while (m_phase != PH_IDLE) begin
      if (n == 3 || $urandom_range(0, 99) < noise_pct)
        send_item(OP_START, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
      else
        send_item(OP_TICK, 4'($urandom_range(0, 15)), $urandom,
                  rand_line ? logic'($urandom_range(0, 1)) : line_val);
      n++;
    end
  endtask

  task automatic test_idle_ticks();
    send_item(OP_TICK, '0, '0, 1'b0);
    send_item(OP_TICK, '1, '1, 1'b1);
    send_item(OP_TICK, 4'h5, 32'hA5A5_5A5A, 1'b0);
  endtask

  task automatic test_field_extremes();
    run_transfer('1, '1, 1'b0, 1'b1, 0);
    run_transfer('0, '0, 1'b0, 1'b0, 0);
    send_item(OP_TICK, '1, '1, 1'b1);
  endtask

  task automatic test_timing_extremes();
    // zero half period and zero turnaround act as one
    set_timing(8'd0, 8'd0);
    run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 3);
    set_timing(8'd1, 8'hF8 | 8'd7);
    run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 3);
    set_timing(8'd2, 8'd4);
    run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 3);
  endtask

  task automatic test_backpressure();
    set_timing(8'd1, 8'd2);
    gaps_on = 1'b0;
    hold_req++;
    run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 3);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_transfers();
    int first;
    logic [CFG_DAT_W-1:0] hp;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      hp = ($urandom_range(0, 5) == 0) ? CFG_DAT_W'($urandom_range(4, 9))
                                       : CFG_DAT_W'($urandom_range(0, 3));
      set_timing(hp, {5'($urandom_range(0, 31)), 3'($urandom_range(0, 7))});
      repeat ($urandom_range(1, 3)) begin
        run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 4);
        repeat ($urandom_range(0, 2))
          send_item(OP_TICK, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_slowest_timing();
    gaps_on = 1'b0;
    set_timing(8'd3, 8'd7);
    run_transfer(4'($urandom_range(0, 15)), $urandom, 1'b1, 1'b0, 1);
  endtask

  // result side: long hold-off on request, random stalls otherwise while gaps_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      stall_left   <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    pin_state_t want;
    pin_state_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pin_q.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected", $time);
      end else begin
        want = pin_q.pop_front();
        got  = {out_ch.swclk_level, out_ch.swdio_level, out_ch.swdio_drive,
                out_ch.ack_code, out_ch.busy_res, out_ch.done_res};
        if (got !== want) begin
          errors++;
          $display("%0t: pins expected %b actual %b", $time, want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_TICK;
    in_ch.request_bits <= '0;
    in_ch.write_data   <= '0;
    in_ch.swdio_in     <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= REG_HALF_PERIOD;
    cfg_ch.wdata       <= '0;
    cfg_half   = 8'd1;
    cfg_turn   = 3'd1;
    m_phase    = PH_IDLE;
    m_bit      = '0;
    m_hp_cnt   = '0;
    m_clk_high = 1'b1;
    m_shift    = '0;
    m_hdr      = '0;
    m_par      = 1'b0;
    m_ack      = '0;
    m_line     = 1'b1;
    m_drive    = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_field_extremes();
    test_timing_extremes();
    test_backpressure();
    test_random_transfers();
    test_slowest_timing();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
